// ===== design/bbpr_pkg.sv =====
package bbpr_pkg;

  // register indexes on the configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_FILL_RISE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LARGE_ERROR   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MEDIUM_ERROR  = 2'd3;
  localparam int unsigned CfgDataW = 14;

  localparam logic [11:0] WINDOW_WIDTH_RST  = 12'd150;
  localparam logic [9:0]  MIN_FILL_RISE_RST = 10'd15;
  localparam logic [13:0] LARGE_ERROR_RST   = 14'd1000;
  localparam logic [13:0] MEDIUM_ERROR_RST  = 14'd500;

  // frame marker for a shifted command frame
  localparam logic [7:0] FRAME_SHIFTED = 8'hFF;

  // status bit positions
  localparam int unsigned ST_FAIL   = 0;
  localparam int unsigned ST_ACT_LO = 1;
  localparam int unsigned ST_ACT_HI = 2;
  localparam int unsigned ST_LOWCO2 = 4;

  // mode bit positions
  localparam int unsigned MODE_FORCE_IDLE = 0;
  localparam int unsigned MODE_CLR_LOWCO2 = 1;

  localparam logic [1:0] HOLD_NONE  = 2'd0;
  localparam logic [1:0] HOLD_SHORT = 2'd1;
  localparam logic [1:0] HOLD_MID   = 2'd2;
  localparam logic [1:0] HOLD_LONG  = 2'd3;

  typedef struct packed {
    logic [11:0] window_width;
    logic [9:0]  min_fill_rise;
    logic [13:0] large_error;
    logic [13:0] medium_error;
  } cfg_t;

  typedef struct packed {
    logic [7:0] sensor_msb;
    logic [7:0] sensor_lsb;
    logic [7:0] frame_byte0;
    logic [7:0] frame_byte1;
    logic [7:0] frame_byte2;
    logic [7:0] frame_byte3;
  } in_item_t;

  typedef struct packed {
    logic [7:0] report_low;
    logic [7:0] report_high;
    logic [7:0] report_status;
    logic       vent_valve;
    logic       fill_valve;
    logic       boost_enable;
    logic [1:0] hold_periods;
  } out_item_t;

endpackage

// ===== design/bbpr_core.sv =====
module bbpr_core import bbpr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  in_item_t  item,
  input  logic      step_en,
  output out_item_t res
);

  logic [15:0] prev_r, prev_nxt;
  logic [15:0] target_r, target_nxt;
  logic [7:0]  mode_r, mode_nxt;
  logic [7:0]  status_r, status_nxt;
  logic        adjusting_r, adjusting_nxt;
  logic        has_filled_r, has_filled_nxt;

  logic [15:0] cur;
  logic [7:0]  st_rep;
  logic [16:0] cur_plus_w;
  logic [16:0] tgt_plus_w;
  logic [16:0] prev_plus_rise;
  logic        below, above, empty;
  logic [15:0] diff;

  assign cur = {item.sensor_msb, item.sensor_lsb};

  always_comb begin
    // idle and failure update, reported as is
    st_rep = status_r;
    if (!adjusting_r) begin
      st_rep[ST_ACT_LO] = 1'b1;
      st_rep[ST_ACT_HI] = 1'b0;
    end
    st_rep[ST_FAIL] = (item.sensor_msb[7:6] == 2'b11) || (cur == 16'd0);

    // command frame
    target_nxt = target_r;
    mode_nxt   = mode_r;
    if ((item.frame_byte0 != 8'd0) || (item.frame_byte1 != 8'd0)) begin
      if (item.frame_byte0 == FRAME_SHIFTED) begin
        target_nxt = {item.frame_byte2, item.frame_byte1};
        mode_nxt   = item.frame_byte3;
      end else begin
        target_nxt = {item.frame_byte1, item.frame_byte0};
        mode_nxt   = item.frame_byte2;
      end
    end
    status_nxt = st_rep;
    if (mode_nxt[MODE_CLR_LOWCO2]) status_nxt[ST_LOWCO2] = 1'b0;
    if (mode_nxt[MODE_FORCE_IDLE]) target_nxt = cur;

    // exact window compare, no wrap
    cur_plus_w     = {1'b0, cur} + {5'd0, cfg.window_width};
    tgt_plus_w     = {1'b0, target_nxt} + {5'd0, cfg.window_width};
    prev_plus_rise = {1'b0, prev_r} + {7'd0, cfg.min_fill_rise};
    below = cur_plus_w < {1'b0, target_nxt};
    above = {1'b0, cur} > tgt_plus_w;
    empty = ({1'b0, cur} < prev_plus_rise) && has_filled_r;
    diff  = (target_nxt > cur) ? (target_nxt - cur) : (cur - target_nxt);

    res.report_low    = item.sensor_lsb;
    res.report_high   = item.sensor_msb;
    res.report_status = st_rep;
    res.vent_valve    = 1'b0;
    res.fill_valve    = 1'b0;
    res.boost_enable  = 1'b0;
    res.hold_periods  = HOLD_NONE;
    adjusting_nxt     = 1'b0;
    has_filled_nxt    = has_filled_r;

    if ((target_nxt != 16'd0) && (below || above)) begin
      adjusting_nxt = 1'b1;
      if (below) begin
        status_nxt[ST_ACT_LO] = 1'b1;
        status_nxt[ST_ACT_HI] = 1'b1;
        if (empty) begin
          status_nxt[ST_LOWCO2] = 1'b1;
          adjusting_nxt = 1'b0;
        end else begin
          status_nxt[ST_LOWCO2] = 1'b0;
          has_filled_nxt   = 1'b1;
          res.fill_valve   = 1'b1;
          res.boost_enable = 1'b1;
        end
      end else begin
        status_nxt[ST_ACT_LO] = 1'b0;
        status_nxt[ST_ACT_HI] = 1'b1;
        res.vent_valve   = 1'b1;
        res.boost_enable = 1'b1;
      end
      if (!(below && empty)) begin
        if (diff > {2'd0, cfg.large_error}) begin
          res.hold_periods = HOLD_LONG;
        end else if (diff > {2'd0, cfg.medium_error}) begin
          res.hold_periods = HOLD_MID;
        end else begin
          res.hold_periods = HOLD_SHORT;
        end
      end
    end
    prev_nxt = cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r       <= '0;
      target_r     <= '0;
      mode_r       <= '0;
      status_r     <= '0;
      adjusting_r  <= 1'b0;
      has_filled_r <= 1'b0;
    end else if (step_en) begin
      prev_r       <= prev_nxt;
      target_r     <= target_nxt;
      mode_r       <= mode_nxt;
      status_r     <= status_nxt;
      adjusting_r  <= adjusting_nxt;
      has_filled_r <= has_filled_nxt;
    end
  end

endmodule

// ===== design/bang_bang_pressure_regulator.sv =====
// bang-bang pressure regulator
// input channel: one beat carries a 16-bit sensor sample (msb and lsb bytes)
//   and the four bytes of the currently held command frame
// result channel: one beat per input beat, in order, with the reading echoed
//   back, the status byte, the valve and boost drives and the hold length
// configuration: plain write port, cfg_we with cfg_index selects the window
//   width, minimum fill rise, large and medium error thresholds; write only
//   while the block is idle
// latency: two cycles from an accepted input beat to its result beat (one
//   cycle in the input register, the decision logic, then the result register)
// throughput: one beat per cycle; the only loop is the one-cycle update of
//   the regulator state (previous reading, target, mode, status, flags)
// stall: when out_stall holds the result register, the input register still
//   takes one more beat; after that in_stall is raised until the result moves
// reset: rst_n low for a clock edge clears both valid flags and the regulator
//   state and loads the configuration registers with their defaults
module bang_bang_pressure_regulator import bbpr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_sensor_msb,
  input  logic [7:0]          in_sensor_lsb,
  input  logic [7:0]          in_frame_byte0,
  input  logic [7:0]          in_frame_byte1,
  input  logic [7:0]          in_frame_byte2,
  input  logic [7:0]          in_frame_byte3,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_report_low,
  output logic [7:0]          out_report_high,
  output logic [7:0]          out_report_status,
  output logic                out_vent_valve,
  output logic                out_fill_valve,
  output logic                out_boost_enable,
  output logic [1:0]          out_hold_periods,
  // configuration
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t      cfg_r;
  in_item_t  in_item_r;
  logic      in_vld_r;
  out_item_t out_item_r;
  logic      out_vld_r;
  out_item_t step_res;
  logic      advance;
  logic      step_en;

  // result register free or being emptied this cycle
  assign advance  = !out_vld_r || !out_stall;
  assign step_en  = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_width  <= WINDOW_WIDTH_RST;
      cfg_r.min_fill_rise <= MIN_FILL_RISE_RST;
      cfg_r.large_error   <= LARGE_ERROR_RST;
      cfg_r.medium_error  <= MEDIUM_ERROR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_WIDTH:  cfg_r.window_width  <= cfg_data[11:0];
        CFG_MIN_FILL_RISE: cfg_r.min_fill_rise <= cfg_data[9:0];
        CFG_LARGE_ERROR:   cfg_r.large_error   <= cfg_data[13:0];
        CFG_MEDIUM_ERROR:  cfg_r.medium_error  <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // input register: loads whenever it is not held by a stalled result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r.sensor_msb  <= in_sensor_msb;
      in_item_r.sensor_lsb  <= in_sensor_lsb;
      in_item_r.frame_byte0 <= in_frame_byte0;
      in_item_r.frame_byte1 <= in_frame_byte1;
      in_item_r.frame_byte2 <= in_frame_byte2;
      in_item_r.frame_byte3 <= in_frame_byte3;
    end
  end

  // decision logic and regulator state
  bbpr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .item    (in_item_r),
    .step_en (step_en),
    .res     (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_item_r <= step_res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_report_low    = out_item_r.report_low;
  assign out_report_high   = out_item_r.report_high;
  assign out_report_status = out_item_r.report_status;
  assign out_vent_valve    = out_item_r.vent_valve;
  assign out_fill_valve    = out_item_r.fill_valve;
  assign out_boost_enable  = out_item_r.boost_enable;
  assign out_hold_periods  = out_item_r.hold_periods;

endmodule
